@@ rtl/smmd_pkg.sv @@
// Shared types, codes and the base64 digit table for the source map decoder.
package smmd_pkg;

	localparam int CHAR_W   = 8;
	localparam int DIGIT_W  = 6;
	localparam int VAL_W    = 32;
	localparam int LINE_W   = 31;
	localparam int SHIFT_W  = 6;
	localparam int FCOUNT_W = 3;
	localparam int OUT_W    = 160;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W   = 1;
	localparam int QCNT_W   = 2;

	localparam logic [CHAR_W-1:0]   CHAR_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0]   CHAR_SEMI  = 8'h3B;
	localparam logic [SHIFT_W-1:0]  SHIFT_STEP = 6'd5;
	localparam logic [SHIFT_W-1:0]  SHIFT_CAP  = 6'd35;
	localparam logic [SHIFT_W-1:0]  SHIFT_LIM  = 6'd32;
	localparam logic [FCOUNT_W-1:0] FCOUNT_MAX = 3'd7;
	localparam logic [FCOUNT_W-1:0] FCOUNT_MIN_OK = 3'd4;
	localparam logic [FCOUNT_W-1:0] FCOUNT_MAX_OK = 3'd5;
	localparam logic [LINE_W-1:0]   LINE_MAX   = 31'h7FFF_FFFF;
	localparam logic [LINE_W-1:0]   LINE_FIRST = 31'd1;

	typedef enum logic [1:0] {
		KIND_DIGIT = 2'd0,
		KIND_BAD   = 2'd1,
		KIND_COMMA = 2'd2,
		KIND_SEMI  = 2'd3
	} kind_t;

	typedef enum logic [FCOUNT_W-1:0] {
		FIELD_GCOL = 3'd0,
		FIELD_SIDX = 3'd1,
		FIELD_OLINE = 3'd2,
		FIELD_OCOL = 3'd3
	} field_t;

	typedef struct packed {
		kind_t              kind;
		logic [DIGIT_W-1:0] digit;
		logic               last;
	} item_t;

	function automatic item_t classify(input logic [CHAR_W-1:0] c, input logic last);
		item_t it;
		it.kind  = KIND_DIGIT;
		it.digit = '0;
		it.last  = last;
		if (c == CHAR_COMMA) begin
			it.kind = KIND_COMMA;
		end else if (c == CHAR_SEMI) begin
			it.kind = KIND_SEMI;
		end else if (c inside {[8'h41:8'h5A]}) begin
			it.digit = DIGIT_W'(c - 8'h41);
		end else if (c inside {[8'h61:8'h7A]}) begin
			it.digit = DIGIT_W'(c - 8'h61 + 8'd26);
		end else if (c inside {[8'h30:8'h39]}) begin
			it.digit = DIGIT_W'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			it.digit = 6'd62;
		end else if (c == 8'h2F) begin
			it.digit = 6'd63;
		end else begin
			it.kind = KIND_BAD;
		end
		return it;
	endfunction

endpackage

@@ rtl/smmd_front.sv @@
// Front end: classify each incoming character into a decoded item.
module smmd_front import smmd_pkg::*; (
	input  logic [CHAR_W-1:0] char_code,
	input  logic              end_of_text,
	output item_t             item
);

	assign item = classify(char_code, end_of_text);

endmodule

@@ rtl/smmd_queue.sv @@
// Two-entry item queue between the front end and the execution back end.
module smmd_queue import smmd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  nonempty,
	output item_t head
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/smmd_back.sv @@
// Back end: VLQ folding, running deltas, segment flush and the output register.
module smmd_back import smmd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  item_t            item,
	output logic             item_take,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata
);

	logic [VAL_W-1:0]    acc_q;
	logic [SHIFT_W-1:0]  shift_q;
	logic [FCOUNT_W-1:0] fcount_q;
	logic                bad_q;
	logic                has_q;
	logic [VAL_W-1:0]    gcol_q;
	logic [VAL_W-1:0]    sidx_q;
	logic [VAL_W-1:0]    oline_q;
	logic [VAL_W-1:0]    ocol_q;
	logic [LINE_W-1:0]   line_q;
	logic [OUT_W-1:0]    out_q;
	logic                out_valid_q;

	logic                is_sep;
	logic [VAL_W-1:0]    acc_or;
	logic [SHIFT_W-1:0]  shift_sum;
	logic [SHIFT_W-1:0]  shift_sat;
	logic [VAL_W-1:0]    mag;
	logic [VAL_W-1:0]    opd;
	logic [VAL_W-1:0]    sum;
	logic                done;

	logic [VAL_W-1:0]    p_acc;
	logic [SHIFT_W-1:0]  p_shift;
	logic [FCOUNT_W-1:0] p_fcount;
	logic                p_bad;
	logic                p_has;
	logic [VAL_W-1:0]    p_gcol;
	logic [VAL_W-1:0]    p_sidx;
	logic [VAL_W-1:0]    p_oline;
	logic [VAL_W-1:0]    p_ocol;
	logic                p_err;
	logic                emit;

	assign is_sep    = (item.kind == KIND_COMMA) || (item.kind == KIND_SEMI);
	assign item_take = item_valid && (!out_valid_q || m_tready);

	assign acc_or    = (shift_q < SHIFT_LIM)
		? (acc_q | (VAL_W'(item.digit[4:0]) << shift_q[4:0])) : acc_q;
	assign shift_sum = shift_q + SHIFT_STEP;
	assign shift_sat = (shift_sum > SHIFT_CAP) ? SHIFT_CAP : shift_sum;
	assign mag       = {1'b0, acc_or[VAL_W-1:1]};
	assign done      = !item.digit[DIGIT_W-1];

	always_comb begin
		case (field_t'(fcount_q))
			FIELD_GCOL:  opd = gcol_q;
			FIELD_SIDX:  opd = sidx_q;
			FIELD_OLINE: opd = oline_q;
			FIELD_OCOL:  opd = ocol_q;
			default:     opd = '0;
		endcase
	end

	assign sum = acc_or[0] ? (opd - mag) : (opd + mag);

	always_comb begin
		p_acc    = acc_q;
		p_shift  = shift_q;
		p_fcount = fcount_q;
		p_bad    = bad_q;
		p_has    = has_q;
		p_gcol   = gcol_q;
		p_sidx   = sidx_q;
		p_oline  = oline_q;
		p_ocol   = ocol_q;
		case (item.kind)
			KIND_BAD: begin
				p_has = 1'b1;
				p_bad = 1'b1;
			end
			KIND_DIGIT: begin
				p_has = 1'b1;
				if (!done) begin
					p_acc   = acc_or;
					p_shift = shift_sat;
				end else begin
					p_acc   = '0;
					p_shift = '0;
					if (fcount_q != FCOUNT_MAX) begin
						p_fcount = fcount_q + 1'b1;
					end
					case (field_t'(fcount_q))
						FIELD_GCOL:  p_gcol  = sum;
						FIELD_SIDX:  p_sidx  = sum;
						FIELD_OLINE: p_oline = sum;
						FIELD_OCOL:  p_ocol  = sum;
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	assign p_err = p_bad || (p_fcount < FCOUNT_MIN_OK) || (p_fcount > FCOUNT_MAX_OK)
		|| (p_shift != '0);
	assign emit  = is_sep ? has_q : item.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			shift_q  <= '0;
			fcount_q <= '0;
			bad_q    <= 1'b0;
			has_q    <= 1'b0;
			gcol_q   <= '0;
			sidx_q   <= '0;
			oline_q  <= '0;
			ocol_q   <= '0;
			line_q   <= LINE_FIRST;
		end else if (item_take) begin
			if (item.last) begin
				acc_q    <= '0;
				shift_q  <= '0;
				fcount_q <= '0;
				bad_q    <= 1'b0;
				has_q    <= 1'b0;
				gcol_q   <= '0;
				sidx_q   <= '0;
				oline_q  <= '0;
				ocol_q   <= '0;
				line_q   <= LINE_FIRST;
			end else if (is_sep) begin
				acc_q    <= '0;
				shift_q  <= '0;
				fcount_q <= '0;
				bad_q    <= 1'b0;
				has_q    <= 1'b0;
				if (item.kind == KIND_SEMI) begin
					gcol_q <= '0;
					if (line_q != LINE_MAX) begin
						line_q <= line_q + 1'b1;
					end
				end
			end else begin
				acc_q    <= p_acc;
				shift_q  <= p_shift;
				fcount_q <= p_fcount;
				bad_q    <= p_bad;
				has_q    <= p_has;
				gcol_q   <= p_gcol;
				sidx_q   <= p_sidx;
				oline_q  <= p_oline;
				ocol_q   <= p_ocol;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take && emit) begin
			out_q <= {p_err, p_gcol, line_q, p_ocol, p_oline, p_sidx};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_take && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

@@ rtl/source_map_mapping_decoder_unit.sv @@
// Top level of the source map mappings decoder.
//
//  channel | direction | payload
//  s_*     | in        | s_tdata[7:0] char_code, s_tlast end_of_text
//  m_*     | out       | m_tdata: src_index, original_line, original_column,
//          |           |          generated_line, generated_column, segment_error
//
// One character per cycle sustained while the output is not stalled; each character is
// classified into the queue, and the back end registers the result when it takes the item
// from the queue. The execute stage folds a VLQ digit and does one add or subtract per cycle
// while the output is not stalled. Reset clears the queue pointers, the output valid flag and all running state.
// A stalled output holds the back end; the two-entry queue keeps s_tready high
// until it fills.
module source_map_mapping_decoder_unit import smmd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,  // [7:0] char_code
	input  logic             s_tlast,  // end_of_text
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // [31:0] src_index, [63:32] original_line,
	                                   // [95:64] original_column, [126:96] generated_line,
	                                   // [158:127] generated_column, [159] segment_error
);

	item_t front_item;
	item_t head_item;
	logic  q_full;
	logic  q_nonempty;
	logic  q_pop;
	logic  q_push;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	smmd_front u_front (
		.char_code   (s_tdata),
		.end_of_text (s_tlast),
		.item        (front_item)
	);

	smmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.head      (head_item)
	);

	smmd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_nonempty),
		.item       (head_item),
		.item_take  (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

@@ rtl/smmd_checker.sv @@
// Port-level checks on the decoder, bound to the top level.
module smmd_checker import smmd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output item changed");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[126:96] != 31'd0)
		else $error("generated line is zero");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("output valid during reset");

	a_ready_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> !$past(m_tvalid && m_tready) || s_tready || s_tvalid)
		else $error("input stall inconsistent");

endmodule

bind source_map_mapping_decoder_unit smmd_checker u_smmd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
